// ===== rtl/bwec_pkg.sv =====
// shared types, codes and saturation helpers for the ball wall and collision stepper
package bwec_pkg;

	localparam int BALLS_DEF = 8;
	localparam int MAX_SLOTS = 8;
	localparam int POS_W = 20;
	localparam int VEL_W = 24;
	localparam int DT_W = 16;
	localparam int LIM_W = 19;
	localparam int ACT_W = 4;
	localparam int IDX_W = 3;
	localparam int CFG_W = 2;
	localparam int QW = 25;
	localparam int WORD_W = 2 * POS_W + 2 * VEL_W;

	localparam logic [CFG_W-1:0] CFG_ACTIVE  = 2'd0;
	localparam logic [CFG_W-1:0] CFG_WALL    = 2'd1;
	localparam logic [CFG_W-1:0] CFG_CONTACT = 2'd2;

	typedef logic [4:0] op_t;

	localparam op_t OP_NONE  = 5'd0;
	localparam op_t OP_LOAD  = 5'd1;
	localparam op_t OP_STEP  = 5'd2;
	localparam op_t OP_READ  = 5'd3;
	localparam op_t OP_LD_I  = 5'd4;
	localparam op_t OP_MOVE  = 5'd5;
	localparam op_t OP_POS   = 5'd6;
	localparam op_t OP_WALL  = 5'd7;
	localparam op_t OP_LD_J  = 5'd8;
	localparam op_t OP_SQ    = 5'd9;
	localparam op_t OP_SUM   = 5'd10;
	localparam op_t OP_DOT1  = 5'd11;
	localparam op_t OP_DOT2  = 5'd12;
	localparam op_t OP_MAG   = 5'd13;
	localparam op_t OP_PP    = 5'd14;
	localparam op_t OP_PPS   = 5'd15;
	localparam op_t OP_DIV   = 5'd16;
	localparam op_t OP_APPLY = 5'd17;
	localparam op_t OP_WR_J  = 5'd18;
	localparam op_t OP_WR_I  = 5'd19;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] addr;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
	} dp_stat_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [26:0] v);
		if (v > 27'sd524287)
			return 20'sh7FFFF;
		else if (v < -27'sd524288)
			return 20'sh80000;
		else
			return v[POS_W-1:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [26:0] v);
		if (v > 27'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -27'sd8388608)
			return 24'sh800000;
		else
			return v[VEL_W-1:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
		if (v == 24'sh800000)
			return 24'sh7FFFFF;
		else
			return -v;
	endfunction

endpackage

// ===== rtl/bwec_ram.sv =====
// generic single write, single registered read ram
module bwec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bwec_dp.sv =====
// datapath: ball store, move, wall flip and pair exchange with parallel x and y divider lanes
module bwec_dp import bwec_pkg::*; #(
	parameter int BALLS = BALLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd_i,
	output dp_stat_t                 stat_o,
	input  logic [IDX_W-1:0]         ball_index,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [VEL_W-1:0]  vel_x,
	input  logic signed [VEL_W-1:0]  vel_y,
	input  logic [DT_W-1:0]          time_step,
	input  logic [LIM_W-1:0]         wall_limit,
	input  logic [LIM_W-1:0]         contact_distance,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y
);

	localparam int NB = (BALLS < MAX_SLOTS) ? BALLS : MAX_SLOTS;
	localparam int AW = $clog2(NB);

	logic [NB-1:0]          valid_q;
	logic [AW-1:0]          raddr_q;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [WORD_W-1:0]      wdata;
	logic [WORD_W-1:0]      rdata;
	logic                   rd_ok;
	logic signed [POS_W-1:0] rdx, rdy;
	logic signed [VEL_W-1:0] rdvx, rdvy;

	logic [DT_W-1:0]          dt_q;
	logic [2*LIM_W-1:0]       cd2_q;
	logic signed [POS_W-1:0]  bx_q, by_q, jx_q, jy_q;
	logic signed [VEL_W-1:0]  bvx_q, bvy_q, jvx_q, jvy_q;
	logic signed [40:0]       mvx_q, mvy_q;
	logic signed [20:0]       dx_q, dy_q;
	logic signed [24:0]       dvx_q, dvy_q;
	logic [40:0]              dx2_q, dy2_q;
	logic [41:0]              s_q;
	logic signed [45:0]       pdx_q, pdy_q;
	logic signed [46:0]       dot_q;
	logic [45:0]              dotm_q;
	logic [20:0]              dxm_q, dym_q;
	logic                     negx_q, negy_q;
	logic [43:0]              pplx_q, pphx_q, pply_q, pphy_q;
	logic [41:0]              remx_q, remy_q;
	logic [QW-1:0]            shx_q, shy_q, qx_q, qy_q;

	logic signed [41:0] mrx, mry;
	logic signed [26:0] sumx, sumy;
	logic signed [41:0] sqx, sqy;
	logic signed [46:0] dotn;
	logic [66:0]        prx, pry;
	logic [42:0]        r2x, r2y;
	logic               bitx, bity;
	logic signed [25:0] qsx, qsy;

	assign rd_ok = valid_q[raddr_q];
	assign rdx  = rd_ok ? rdata[WORD_W-1 -: POS_W] : '0;
	assign rdy  = rd_ok ? rdata[WORD_W-1-POS_W -: POS_W] : '0;
	assign rdvx = rd_ok ? rdata[2*VEL_W-1 -: VEL_W] : '0;
	assign rdvy = rd_ok ? rdata[VEL_W-1:0] : '0;

	always_comb begin
		we = 1'b0;
		waddr = cmd_i.addr[AW-1:0];
		wdata = {jx_q, jy_q, jvx_q, jvy_q};
		unique case (cmd_i.op)
			OP_LOAD: begin
				we = ({1'b0, ball_index} < 4'(NB));
				waddr = ball_index[AW-1:0];
				wdata = {pos_x, pos_y, vel_x, vel_y};
			end
			OP_WR_J: we = 1'b1;
			OP_WR_I: begin
				we = 1'b1;
				wdata = {bx_q, by_q, bvx_q, bvy_q};
			end
			default: ;
		endcase
	end

	bwec_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NB)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(cmd_i.addr[AW-1:0]),
		.rdata(rdata)
	);

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_comb begin
		mrx = {mvx_q[40], mvx_q} + 42'sd32768;
		mry = {mvy_q[40], mvy_q} + 42'sd32768;
		sumx = {{7{bx_q[POS_W-1]}}, bx_q} + {mrx[41], mrx[41:16]};
		sumy = {{7{by_q[POS_W-1]}}, by_q} + {mry[41], mry[41:16]};
		sqx = dx_q * dx_q;
		sqy = dy_q * dy_q;
		dotn = -dot_q;
		prx = {pphx_q, 23'b0} + {23'b0, pplx_q};
		pry = {pphy_q, 23'b0} + {23'b0, pply_q};
		r2x = {remx_q, shx_q[QW-1]};
		r2y = {remy_q, shy_q[QW-1]};
		bitx = (r2x >= {1'b0, s_q});
		bity = (r2y >= {1'b0, s_q});
		qsx = negx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
		qsy = negy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
	end

	always_ff @(posedge clk) begin
		raddr_q <= cmd_i.addr[AW-1:0];
		unique case (cmd_i.op)
			OP_STEP: begin
				dt_q <= time_step;
				cd2_q <= contact_distance * contact_distance;
			end
			OP_LD_I: begin
				bx_q <= rdx;
				by_q <= rdy;
				bvx_q <= rdvx;
				bvy_q <= rdvy;
			end
			OP_MOVE: begin
				mvx_q <= bvx_q * $signed({1'b0, dt_q});
				mvy_q <= bvy_q * $signed({1'b0, dt_q});
			end
			OP_POS: begin
				bx_q <= sat_pos(sumx);
				by_q <= sat_pos(sumy);
			end
			OP_WALL: begin
				// right, left, top, bottom, first match only
				if (!bvx_q[VEL_W-1] && bvx_q != '0 &&
						$signed({bx_q[POS_W-1], bx_q}) > $signed({2'b0, wall_limit}))
					bvx_q <= neg_vel(bvx_q);
				else if (bvx_q[VEL_W-1] && bx_q[POS_W-1])
					bvx_q <= neg_vel(bvx_q);
				else if (bvy_q[VEL_W-1] && by_q[POS_W-1])
					bvy_q <= neg_vel(bvy_q);
				else if (!bvy_q[VEL_W-1] && bvy_q != '0 &&
						$signed({by_q[POS_W-1], by_q}) > $signed({2'b0, wall_limit}))
					bvy_q <= neg_vel(bvy_q);
			end
			OP_LD_J: begin
				jx_q <= rdx;
				jy_q <= rdy;
				jvx_q <= rdvx;
				jvy_q <= rdvy;
				dx_q <= {rdx[POS_W-1], rdx} - {bx_q[POS_W-1], bx_q};
				dy_q <= {rdy[POS_W-1], rdy} - {by_q[POS_W-1], by_q};
				dvx_q <= {rdvx[VEL_W-1], rdvx} - {bvx_q[VEL_W-1], bvx_q};
				dvy_q <= {rdvy[VEL_W-1], rdvy} - {bvy_q[VEL_W-1], bvy_q};
			end
			OP_SQ: begin
				dx2_q <= sqx[40:0];
				dy2_q <= sqy[40:0];
			end
			OP_SUM: s_q <= {1'b0, dx2_q} + {1'b0, dy2_q};
			OP_DOT1: begin
				pdx_q <= dvx_q * dx_q;
				pdy_q <= dvy_q * dy_q;
			end
			OP_DOT2: dot_q <= {pdx_q[45], pdx_q} + {pdy_q[45], pdy_q};
			OP_MAG: begin
				dotm_q <= dot_q[46] ? dotn[45:0] : dot_q[45:0];
				dxm_q <= dx_q[20] ? 21'(-dx_q) : 21'(dx_q);
				dym_q <= dy_q[20] ? 21'(-dy_q) : 21'(dy_q);
				negx_q <= dot_q[46] ^ dx_q[20];
				negy_q <= dot_q[46] ^ dy_q[20];
			end
			OP_PP: begin
				pplx_q <= dotm_q[22:0] * dxm_q;
				pphx_q <= dotm_q[45:23] * dxm_q;
				pply_q <= dotm_q[22:0] * dym_q;
				pphy_q <= dotm_q[45:23] * dym_q;
			end
			OP_PPS: begin
				// quotient fits QW bits, so the top part starts below s
				remx_q <= prx[66:QW];
				remy_q <= pry[66:QW];
				shx_q <= prx[QW-1:0];
				shy_q <= pry[QW-1:0];
				qx_q <= '0;
				qy_q <= '0;
			end
			OP_DIV: begin
				remx_q <= bitx ? 42'(r2x - {1'b0, s_q}) : r2x[41:0];
				remy_q <= bity ? 42'(r2y - {1'b0, s_q}) : r2y[41:0];
				shx_q <= {shx_q[QW-2:0], 1'b0};
				shy_q <= {shy_q[QW-2:0], 1'b0};
				qx_q <= {qx_q[QW-2:0], bitx};
				qy_q <= {qy_q[QW-2:0], bity};
			end
			OP_APPLY: begin
				jvx_q <= sat_vel({{3{jvx_q[VEL_W-1]}}, jvx_q} - {qsx[25], qsx});
				jvy_q <= sat_vel({{3{jvy_q[VEL_W-1]}}, jvy_q} - {qsy[25], qsy});
				bvx_q <= sat_vel({{3{bvx_q[VEL_W-1]}}, bvx_q} + {qsx[25], qsx});
				bvy_q <= sat_vel({{3{bvy_q[VEL_W-1]}}, bvy_q} + {qsy[25], qsy});
			end
			default: ;
		endcase
	end

	assign stat_o.skip = (s_q >= {4'b0, cd2_q}) || (s_q == '0);
	assign out_x = bx_q;
	assign out_y = by_q;

endmodule

// ===== rtl/bwec_ctrl.sv =====
// controller: walks balls and later pairs, sequences the datapath
module bwec_ctrl import bwec_pkg::*; #(
	parameter int BALLS = BALLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cmd,
	input  logic [ACT_W-1:0] active_balls,
	input  dp_stat_t         stat_i,
	output dp_cmd_t          cmd_o,
	output logic             busy,
	output logic             result_valid,
	output logic [IDX_W-1:0] out_index,
	output logic             last
);

	localparam int NB = (BALLS < MAX_SLOTS) ? BALLS : MAX_SLOTS;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RDI   = 5'd1;
	localparam logic [4:0] S_LDI   = 5'd2;
	localparam logic [4:0] S_MOVE  = 5'd3;
	localparam logic [4:0] S_POS   = 5'd4;
	localparam logic [4:0] S_WALL  = 5'd5;
	localparam logic [4:0] S_RDJ   = 5'd6;
	localparam logic [4:0] S_LDJ   = 5'd7;
	localparam logic [4:0] S_SQ    = 5'd8;
	localparam logic [4:0] S_SUM   = 5'd9;
	localparam logic [4:0] S_CHK   = 5'd10;
	localparam logic [4:0] S_DOT1  = 5'd11;
	localparam logic [4:0] S_DOT2  = 5'd12;
	localparam logic [4:0] S_MAG   = 5'd13;
	localparam logic [4:0] S_PP    = 5'd14;
	localparam logic [4:0] S_PPS   = 5'd15;
	localparam logic [4:0] S_DIV   = 5'd16;
	localparam logic [4:0] S_APPLY = 5'd17;
	localparam logic [4:0] S_WRJ   = 5'd18;
	localparam logic [4:0] S_WRI   = 5'd19;

	logic [4:0]       state_q, state_d;
	logic [ACT_W-1:0] n_q, i_q, j_q, n_calc, i_inc, j_inc;
	logic [4:0]       k_q;

	assign n_calc = (active_balls < 4'(NB)) ? active_balls : 4'(NB);
	assign i_inc = i_q + 4'd1;
	assign j_inc = j_q + 4'd1;

	always_comb begin
		state_d = state_q;
		cmd_o.op = OP_NONE;
		cmd_o.addr = i_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd) begin
						cmd_o.op = OP_STEP;
						if (n_calc != '0)
							state_d = S_RDI;
					end else begin
						cmd_o.op = OP_LOAD;
					end
				end
			end
			S_RDI: begin
				cmd_o.op = OP_READ;
				state_d = S_LDI;
			end
			S_LDI: begin
				cmd_o.op = OP_LD_I;
				state_d = S_MOVE;
			end
			S_MOVE: begin
				cmd_o.op = OP_MOVE;
				state_d = S_POS;
			end
			S_POS: begin
				cmd_o.op = OP_POS;
				state_d = S_WALL;
			end
			S_WALL: begin
				cmd_o.op = OP_WALL;
				state_d = (i_inc < n_q) ? S_RDJ : S_WRI;
			end
			S_RDJ: begin
				cmd_o.op = OP_READ;
				cmd_o.addr = j_q[IDX_W-1:0];
				state_d = S_LDJ;
			end
			S_LDJ: begin
				cmd_o.op = OP_LD_J;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd_o.op = OP_SQ;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd_o.op = OP_SUM;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!stat_i.skip)
					state_d = S_DOT1;
				else
					state_d = (j_inc < n_q) ? S_RDJ : S_WRI;
			end
			S_DOT1: begin
				cmd_o.op = OP_DOT1;
				state_d = S_DOT2;
			end
			S_DOT2: begin
				cmd_o.op = OP_DOT2;
				state_d = S_MAG;
			end
			S_MAG: begin
				cmd_o.op = OP_MAG;
				state_d = S_PP;
			end
			S_PP: begin
				cmd_o.op = OP_PP;
				state_d = S_PPS;
			end
			S_PPS: begin
				cmd_o.op = OP_PPS;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd_o.op = OP_DIV;
				if (k_q == '0)
					state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd_o.op = OP_APPLY;
				state_d = S_WRJ;
			end
			S_WRJ: begin
				cmd_o.op = OP_WR_J;
				cmd_o.addr = j_q[IDX_W-1:0];
				state_d = (j_inc < n_q) ? S_RDJ : S_WRI;
			end
			S_WRI: begin
				cmd_o.op = OP_WR_I;
				state_d = (i_inc < n_q) ? S_RDI : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start && cmd) begin
				n_q <= n_calc;
				i_q <= '0;
			end
			if (state_q == S_WALL)
				j_q <= i_inc;
			if (state_q == S_WRJ || (state_q == S_CHK && stat_i.skip))
				j_q <= j_inc;
			if (state_q == S_WRI)
				i_q <= i_inc;
			if (state_q == S_PPS)
				k_q <= 5'(QW - 1);
			else if (state_q == S_DIV)
				k_q <= k_q - 5'd1;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign result_valid = (state_q == S_WALL);
	assign out_index = i_q[IDX_W-1:0];
	assign last = (i_inc == n_q);

endmodule

// ===== rtl/ball_wall_and_elastic_collision_step.sv =====
// top level: config registers, controller and datapath of the ball stepper
//
// command port: a word is taken at a clock edge with start high and busy low.
// cmd 0 loads one ball (position, velocity) into slot ball_index; slots at
// or above the ball count are ignored, and busy stays low. cmd 1 steps the
// first active_balls balls (at most the ball count) by time_step: unless
// none are active, busy rises and stays high until the step is done. each
// ball gives one result word, strobed by result_valid for one cycle with
// out_index, out_x, out_y, and last on the final ball. the receiver cannot
// stall; results simply go by. per ball: read, load, move, position, wall
// check and write back; per later ball: read, load, square, sum, distance
// test, and in contact also dot, magnitude, products, bit-serial divider
// (25 quotient bits, x and y lanes in parallel), apply and write back. config
// is written through cfg_we / cfg_index / cfg_data; the user must do so only
// while idle, the block does not enforce it. reset clears all balls to zero
// and restores active_balls 3, wall_limit 750 px and contact_distance 50 px.
module ball_wall_and_elastic_collision_step import bwec_pkg::*; #(
	parameter int BALLS = BALLS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    cmd,
	input  logic [IDX_W-1:0]        ball_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [VEL_W-1:0] vel_x,
	input  logic signed [VEL_W-1:0] vel_y,
	input  logic [DT_W-1:0]         time_step,
	output logic                    result_valid,
	output logic [IDX_W-1:0]        out_index,
	output logic signed [POS_W-1:0] out_x,
	output logic signed [POS_W-1:0] out_y,
	output logic                    last,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_index,
	input  logic [LIM_W-1:0]        cfg_data
);

	logic [ACT_W-1:0] active_q;
	logic [LIM_W-1:0] wall_q, contact_q;
	dp_cmd_t          dp_cmd;
	dp_stat_t         dp_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 4'd3;
			wall_q <= 19'd192000;
			contact_q <= 19'd12800;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE:  active_q <= cfg_data[ACT_W-1:0];
				CFG_WALL:    wall_q <= cfg_data;
				CFG_CONTACT: contact_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bwec_ctrl #(
		.BALLS(BALLS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.active_balls(active_q),
		.stat_i      (dp_stat),
		.cmd_o       (dp_cmd),
		.busy        (busy),
		.result_valid(result_valid),
		.out_index   (out_index),
		.last        (last)
	);

	bwec_dp #(
		.BALLS(BALLS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_i           (dp_cmd),
		.stat_o          (dp_stat),
		.ball_index      (ball_index),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.vel_x           (vel_x),
		.vel_y           (vel_y),
		.time_step       (time_step),
		.wall_limit      (wall_q),
		.contact_distance(contact_q),
		.out_x           (out_x),
		.out_y           (out_y)
	);

endmodule

// ===== verif/tb_ball_wall_and_elastic_collision_step.sv =====
// testbench for the ball stepper: directed table, then clustered random loads and steps
`timescale 1ns / 1ps

module tb_ball_wall_and_elastic_collision_step;
	import bwec_pkg::*;

	localparam int WATCH_LIMIT = 20000;
	localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		bit                      cmd;
		logic [IDX_W-1:0]        idx;
		logic signed [POS_W-1:0] px, py;
		logic signed [VEL_W-1:0] vx, vy;
		logic [DT_W-1:0]         dt;
		bit                      known;
		logic signed [POS_W-1:0] kx, ky;
	} word_t;

	typedef struct {
		logic [IDX_W-1:0]        idx;
		logic signed [POS_W-1:0] x, y;
		logic                    lst;
	} ball_pos_t;

	logic clk = 0, arst_n = 0;
	logic start = 0, cmd = 0;
	logic [IDX_W-1:0] ball_index = 0;
	logic signed [POS_W-1:0] pos_x = 0, pos_y = 0;
	logic signed [VEL_W-1:0] vel_x = 0, vel_y = 0;
	logic [DT_W-1:0] time_step = 0;
	logic cfg_we = 0;
	logic [CFG_W-1:0] cfg_index = 0;
	logic [LIM_W-1:0] cfg_data = 0;
	logic busy, result_valid, last;
	logic [IDX_W-1:0] out_index;
	logic signed [POS_W-1:0] out_x, out_y;

	ball_wall_and_elastic_collision_step uut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [ACT_W-1:0] act_balls;
	logic [LIM_W-1:0] wall_lim, contact_dist;
	logic signed [POS_W-1:0] bx [8], by [8];
	logic signed [VEL_W-1:0] bvx [8], bvy [8];
	ball_pos_t pos_q [$];
	int errors = 0;
	int idle_pct = 16;
	word_t dir_rows [$];

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint pclamp(longint v);
		return clamp(v, -524288, 524287);
	endfunction

	function automatic longint vclamp(longint v);
		return clamp(v, -8388608, 8388607);
	endfunction

	// num * c / s truncated toward zero
	function automatic longint share_quot(longint num, longint c, longint unsigned s);
		longint unsigned a, b, q;
		a = num < 0 ? -num : num;
		b = c < 0 ? -c : c;
		q = (a / s) * b + ((a % s) * b) / s;
		return ((num < 0) != (c < 0)) ? -longint'(q) : longint'(q);
	endfunction

	task automatic advance_balls(input logic [DT_W-1:0] dt, input word_t w);
		int n;
		longint px, py, vx, vy, dx, dy, s, dot, qx, qy, cd2, wl;
		ball_pos_t e;
		n = act_balls > 8 ? 8 : act_balls;
		wl = longint'(wall_lim);
		cd2 = longint'(contact_dist) * longint'(contact_dist);
		for (int i = 0; i < n; i++) begin
			px = pclamp(longint'(bx[i]) + ((longint'(bvx[i]) * longint'(dt) + 32768) >>> 16));
			py = pclamp(longint'(by[i]) + ((longint'(bvy[i]) * longint'(dt) + 32768) >>> 16));
			bx[i] = px;
			by[i] = py;
			e.idx = i;
			e.x = px;
			e.y = py;
			e.lst = (i + 1 == n);
			if (i == 0 && w.known) begin
				e.x = w.kx;
				e.y = w.ky;
			end
			pos_q.push_back(e);
			vx = bvx[i];
			vy = bvy[i];
			// one wall flip at most: right, left, top, bottom
			if (vx > 0 && px > wl) bvx[i] = vclamp(-vx);
			else if (vx < 0 && px < 0) bvx[i] = vclamp(-vx);
			else if (vy < 0 && py < 0) bvy[i] = vclamp(-vy);
			else if (vy > 0 && py > wl) bvy[i] = vclamp(-vy);
			for (int j = i + 1; j < n; j++) begin
				dx = longint'(bx[j]) - longint'(bx[i]);
				dy = longint'(by[j]) - longint'(by[i]);
				s = dx * dx + dy * dy;
				if (s >= cd2 || s == 0) continue;
				dot = (longint'(bvx[j]) - longint'(bvx[i])) * dx
					+ (longint'(bvy[j]) - longint'(bvy[i])) * dy;
				qx = share_quot(dot, dx, s);
				qy = share_quot(dot, dy, s);
				bvx[j] = vclamp(longint'(bvx[j]) - qx);
				bvy[j] = vclamp(longint'(bvy[j]) - qy);
				bvx[i] = vclamp(longint'(bvx[i]) + qx);
				bvy[i] = vclamp(longint'(bvy[i]) + qy);
			end
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		ball_pos_t e;
		if (arst_n && result_valid) begin
			if (pos_q.size() == 0) begin
				$display("unexpected result word for ball %0d at %0t", out_index, $realtime);
				errors++;
			end else begin
				e = pos_q.pop_front();
				if (out_index !== e.idx) report("out_index", out_index, e.idx);
				if (out_x !== e.x) report("out_x", out_x, e.x);
				if (out_y !== e.y) report("out_y", out_y, e.y);
				if (last !== e.lst) report("last", last, e.lst);
			end
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= WATCH_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send(input word_t w);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		cmd <= w.cmd;
		ball_index <= w.idx;
		pos_x <= w.px;
		pos_y <= w.py;
		vel_x <= w.vx;
		vel_y <= w.vy;
		time_step <= w.dt;
		start <= 1;
		do @(posedge clk); while (busy);
		if (w.cmd) begin
			advance_balls(w.dt, w);
		end else begin
			bx[w.idx] = w.px;
			by[w.idx] = w.py;
			bvx[w.idx] = w.vx;
			bvy[w.idx] = w.vy;
		end
	endtask

	// block must be idle: no words pending, not busy, then a short settle
	task automatic set_config(input logic [ACT_W-1:0] a, input logic [LIM_W-1:0] wl,
			input logic [LIM_W-1:0] cd);
		@(negedge clk);
		start <= 0;
		while (pos_q.size() != 0 || busy) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we <= 1; cfg_index <= CFG_ACTIVE; cfg_data <= LIM_W'(a);
		@(negedge clk);
		cfg_index <= CFG_WALL; cfg_data <= wl;
		@(negedge clk);
		cfg_index <= CFG_CONTACT; cfg_data <= cd;
		@(negedge clk);
		// spare index is ignored
		cfg_index <= CFG_SPARE; cfg_data <= $urandom;
		@(negedge clk);
		cfg_we <= 0;
		act_balls = a;
		wall_lim = wl;
		contact_dist = cd;
	endtask

	function automatic word_t mk(bit c, int i, int px, int py, int vx, int vy, int dt,
			bit k = 0, int kx = 0, int ky = 0);
		word_t w;
		w.cmd = c; w.idx = i; w.px = px; w.py = py; w.vx = vx; w.vy = vy; w.dt = dt;
		w.known = k; w.kx = kx; w.ky = ky;
		return w;
	endfunction

	function automatic word_t rand_word(int centre_x, int centre_y, int spread);
		word_t w;
		int r;
		r = $urandom_range(99);
		w = mk(0, 0, 0, 0, 0, 0, 0);
		if (r < 12) begin
			w.cmd = $urandom; w.idx = $urandom; w.px = $urandom; w.py = $urandom;
			w.vx = $urandom; w.vy = $urandom; w.dt = $urandom;
		end else if (r < 32) begin
			w.cmd = 1;
			w.dt = ($urandom_range(9) == 0) ? DT_W'($urandom) : DT_W'($urandom_range(0, 4000));
			w.idx = $urandom;
		end else begin
			w.idx = $urandom_range(0, 7);
			w.px = centre_x + int'($urandom_range(0, 2 * spread)) - spread;
			w.py = centre_y + int'($urandom_range(0, 2 * spread)) - spread;
			w.vx = int'($urandom_range(0, 120000)) - 60000;
			w.vy = int'($urandom_range(0, 120000)) - 60000;
			w.dt = $urandom;
		end
		return w;
	endfunction

	initial begin
		int cx, cy, items;
		act_balls = 3;
		wall_lim = 192000;
		contact_dist = 12800;
		for (int i = 0; i < 8; i++) begin
			bx[i] = 0; by[i] = 0; bvx[i] = 0; bvy[i] = 0;
		end
		// after reset every ball sits still at the origin
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 65535, 1, 0, 0));
		dir_rows.push_back(mk(0, 0, 524287, 524287, 8388607, 8388607, 0));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 65535, 1, 524287, 524287));
		dir_rows.push_back(mk(0, 0, -524288, -524288, -8388608, -8388608, 65535));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 65535, 1, -524288, -524288));
		dir_rows.push_back(mk(1, 7, 0, 0, 0, 0, 0));
		// head-on pair, third ball on top of the second one
		dir_rows.push_back(mk(0, 0, 25600, 25600, 20000, 0, 0));
		dir_rows.push_back(mk(0, 1, 28160, 25600, -20000, 0, 0));
		dir_rows.push_back(mk(0, 2, 28160, 25600, 3000, 7000, 0));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 1000));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 1000));
		// walls: right, left, top, then bottom
		dir_rows.push_back(mk(0, 0, 191800, 100000, 50000, 50000, 0));
		dir_rows.push_back(mk(0, 1, 100, 100, -5000, -5000, 0));
		dir_rows.push_back(mk(0, 2, 76800, 50, 0, -5000, 0));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 2000));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 2000));
		dir_rows.push_back(mk(0, 2, 76800, 191990, 0, 5000, 0));
		dir_rows.push_back(mk(1, 0, 0, 0, 0, 0, 3000));
		dir_rows.push_back(mk(0, 5, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(1, 3, 0, 0, 0, 0, 0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		foreach (dir_rows[k]) send(dir_rows[k]);

		items = 0;
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_config(8, 524287, 524287);
				1: set_config(0, 192000, 12800);
				2: set_config(15, 0, 0);
				3: set_config(1, 192000, 20000);
				4: set_config(8, 0, 30000);
				default: set_config($urandom_range(0, 9) < 8 ? $urandom_range(1, 8)
					: $urandom_range(0, 15), $urandom, $urandom_range(0, 40000));
			endcase
			cx = $urandom_range(0, 200000);
			cy = $urandom_range(0, 200000);
			for (int k = 0; k < 40; k++) begin
				idle_pct = (items >= 150 && items < 250) ? 0 : 16;
				send(rand_word(cx, cy, (ph % 3 == 0) ? 40000 : 8000));
				items++;
			end
		end

		@(negedge clk);
		start <= 0;
		while (pos_q.size() != 0 || busy) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bwec_pkg.sv
rtl/bwec_ram.sv
rtl/bwec_dp.sv
rtl/bwec_ctrl.sv
rtl/ball_wall_and_elastic_collision_step.sv
verif/tb_ball_wall_and_elastic_collision_step.sv
